// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pcpa_pkg.sv =====
// Shared types and constants for the per-CPU page free-list allocator.
// No dependencies; used by the allocator, its adder and its checker.
package pcpa_pkg;

  localparam int ADDR_W = 56;
  localparam int UNIT_W = ADDR_W + 1;

  localparam int CPU_COUNT_DEF  = 8;
  localparam int PAGE_COUNT_DEF = 32768;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam logic [ADDR_W-1:0] BASE_RST = 56'h0000_0080_0000_00;
  localparam logic [ADDR_W-1:0] TOP_RST  = 56'h0000_0088_0000_00;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FREED = 2'd1,
    ST_OOM   = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic {
    CFG_BASE = 1'b0,
    CFG_TOP  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } req_mode_t;

  // Result of the shared adder: carry out and sum.
  typedef struct packed {
    logic              carry;
    logic [UNIT_W-1:0] sum;
  } sum_t;

endpackage

// ===== sv/pcpa_addsub.sv =====
// Shared add/subtract unit used by the arithmetic steps of the allocator sequencer.
// Depends on pcpa_pkg for the operand width and result struct.
module pcpa_addsub (
  input  logic [pcpa_pkg::UNIT_W-1:0] op_a,
  input  logic [pcpa_pkg::UNIT_W-1:0] op_b,
  input  logic                        op_sub,
  output pcpa_pkg::sum_t              res
);

  logic [pcpa_pkg::UNIT_W-1:0] b_eff;
  logic [pcpa_pkg::UNIT_W:0]   total;

  // For a subtraction the carry out is set when op_a >= op_b.
  assign b_eff = op_sub ? ~op_b : op_b;
  assign total = {1'b0, op_a} + {1'b0, b_eff} + {{pcpa_pkg::UNIT_W{1'b0}}, op_sub};
  assign res.carry = total[pcpa_pkg::UNIT_W];
  assign res.sum   = total[pcpa_pkg::UNIT_W-1:0];

endmodule

// ===== sv/per_cpu_page_free_list_allocator_top.sv =====
// Per-CPU LIFO page allocator with whole-list stealing, top level.
// Depends on pcpa_pkg and pcpa_addsub.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall  | in_mode, in_cpu_id, in_page_addr
//  out     | output    | out_valid/out_stall| out_status, out_alloc_addr, out_stolen,
//          |           |                    | out_victim_cpu
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// A free makes five passes through the shared 57-bit adder, then a link write and a result
// hand-off; a rejected free stops at the failing check. An allocation scans the list heads,
// passing empty lists one per cycle (at most CPU_COUNT - 1), then forms the address; out of
// memory is reported once the scan has found every list empty. One request at a time; a
// result waits in the output register while out_stall is high. Reset empties every list;
// the link memory needs no clearing.
module per_cpu_page_free_list_allocator_top #(
  parameter int CPU_COUNT  = pcpa_pkg::CPU_COUNT_DEF,
  parameter int PAGE_COUNT = pcpa_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT = pcpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [2:0]                  in_cpu_id,
  input  logic [pcpa_pkg::ADDR_W-1:0] in_page_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [pcpa_pkg::ADDR_W-1:0] out_alloc_addr,
  output logic                        out_stolen,
  output logic [2:0]                  out_victim_cpu,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pcpa_pkg::ADDR_W-1:0] cfg_wdata
);

  localparam int AW    = pcpa_pkg::ADDR_W;
  localparam int UW    = pcpa_pkg::UNIT_W;
  localparam int CW    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int IDX_W = $clog2(PAGE_COUNT);

  localparam logic [UW-1:0] SPAN_M1 = UW'({PAGE_SHIFT{1'b1}});
  localparam logic [UW-1:0] PAGE_CNT_U = UW'(PAGE_COUNT);
  localparam logic [CW-1:0] LAST_CNT = CW'(CPU_COUNT - 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_FP   = 10'b00_0000_0010,
    S_LOW  = 10'b00_0000_0100,
    S_HIGH = 10'b00_0000_1000,
    S_IDX  = 10'b00_0001_0000,
    S_CNT  = 10'b00_0010_0000,
    S_PUSH = 10'b00_0100_0000,
    S_SCAN = 10'b00_1000_0000,
    S_ADDR = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]    base_r, top_r;
  logic             mode_r;
  logic [CW-1:0]    cpu_r, ptr_r, count_r;
  logic [AW-1:0]    pa_r;
  logic [UW-1:0]    fp_r, diff_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W:0]   rd_r;

  logic             head_vld_r [CPU_COUNT];
  logic [IDX_W-1:0] head_idx_r [CPU_COUNT];
  logic [IDX_W:0]   link_mem   [PAGE_COUNT];

  logic [1:0]       res_status_r;
  logic [AW-1:0]    res_addr_r;
  logic             res_stolen_r;
  logic [2:0]       res_victim_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [AW-1:0]    out_addr_r;
  logic             out_stolen_r;
  logic [2:0]       out_victim_r;

  logic [UW-1:0]    op_a, op_b;
  logic             op_sub;
  pcpa_pkg::sum_t   unit_res;

  logic [6:0]       cpu_red;
  logic             in_xfer, out_free;
  logic             head_vld_sel;
  logic [IDX_W-1:0] head_idx_sel;
  logic [CW+2:0]    ptr_ext;
  logic [AW-1:0]    page_addr_calc;

  pcpa_addsub u_addsub (
    .op_a  (op_a),
    .op_b  (op_b),
    .op_sub(op_sub),
    .res   (unit_res)
  );

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign head_vld_sel = head_vld_r[ptr_r];
  assign head_idx_sel = head_idx_r[ptr_r];
  assign ptr_ext      = {3'b000, ptr_r};

  // Page number to address: low bits of (first page + index), shifted into place.
  assign page_addr_calc = AW'(unit_res.sum << PAGE_SHIFT);

  // CPU index modulo CPU_COUNT by repeated subtraction on a 3-bit value.
  always_comb begin
    cpu_red = 7'(in_cpu_id);
    for (int i = 0; i < 8; i++) begin
      if (cpu_red >= 7'(CPU_COUNT)) begin
        cpu_red = cpu_red - 7'(CPU_COUNT);
      end
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    op_a   = fp_r;
    op_b   = UW'(idx_r);
    op_sub = 1'b0;
    case (state_r)
      S_FP: begin
        op_a   = UW'(base_r);
        op_b   = SPAN_M1;
        op_sub = 1'b0;
      end
      S_LOW: begin
        op_a   = UW'(pa_r);
        op_b   = UW'(base_r);
        op_sub = 1'b1;
      end
      S_HIGH: begin
        op_a   = UW'(pa_r);
        op_b   = UW'(top_r);
        op_sub = 1'b1;
      end
      S_IDX: begin
        op_a   = UW'(pa_r >> PAGE_SHIFT);
        op_b   = fp_r;
        op_sub = 1'b1;
      end
      S_CNT: begin
        op_a   = diff_r;
        op_b   = PAGE_CNT_U;
        op_sub = 1'b1;
      end
      default: begin
        op_a   = fp_r;
        op_b   = UW'(idx_r);
        op_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_FP;
      S_FP:   state_nxt = (mode_r == pcpa_pkg::MODE_FREE) ? S_LOW : S_SCAN;
      S_LOW: begin
        if (!unit_res.carry || (pa_r[PAGE_SHIFT-1:0] != '0)) state_nxt = S_DONE;
        else state_nxt = S_HIGH;
      end
      S_HIGH: state_nxt = unit_res.carry ? S_DONE : S_IDX;
      S_IDX:  state_nxt = S_CNT;
      S_CNT:  state_nxt = unit_res.carry ? S_DONE : S_PUSH;
      S_PUSH: state_nxt = S_DONE;
      S_SCAN: begin
        if (head_vld_sel) state_nxt = S_ADDR;
        else if (count_r == LAST_CNT) state_nxt = S_DONE;
      end
      S_ADDR: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and list heads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= pcpa_pkg::BASE_RST;
      top_r       <= pcpa_pkg::TOP_RST;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CPU_COUNT; c++) begin
        head_vld_r[c] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == pcpa_pkg::CFG_BASE) base_r <= cfg_wdata;
        else top_r <= cfg_wdata;
      end
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == S_PUSH) head_vld_r[cpu_r] <= 1'b1;
      // A stolen list is emptied; the requester's own list is rewritten below.
      if (state_r == S_SCAN && head_vld_sel && count_r != '0) head_vld_r[ptr_r] <= 1'b0;
      if (state_r == S_ADDR) head_vld_r[cpu_r] <= rd_r[IDX_W];
    end
  end

  // Request payload, sequencer data and the result registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r  <= in_mode;
      cpu_r   <= cpu_red[CW-1:0];
      ptr_r   <= cpu_red[CW-1:0];
      count_r <= '0;
      pa_r    <= in_page_addr;
      res_status_r <= pcpa_pkg::ST_BAD;
      res_addr_r   <= '0;
      res_stolen_r <= 1'b0;
      res_victim_r <= '0;
    end
    case (state_r)
      S_FP:  fp_r <= unit_res.sum >> PAGE_SHIFT;
      S_IDX: diff_r <= unit_res.sum;
      S_PUSH: begin
        head_idx_r[cpu_r] <= diff_r[IDX_W-1:0];
        res_status_r      <= pcpa_pkg::ST_FREED;
      end
      S_SCAN: begin
        if (head_vld_sel) begin
          idx_r        <= head_idx_sel;
          res_stolen_r <= (count_r != '0);
          res_victim_r <= (count_r != '0) ? ptr_ext[2:0] : 3'b000;
        end else if (count_r == LAST_CNT) begin
          res_status_r <= pcpa_pkg::ST_OOM;
        end else begin
          ptr_r   <= (ptr_r == LAST_CNT) ? '0 : ptr_r + 1'b1;
          count_r <= count_r + 1'b1;
        end
      end
      S_ADDR: begin
        head_idx_r[cpu_r] <= rd_r[IDX_W-1:0];
        res_status_r      <= pcpa_pkg::ST_ALLOC;
        res_addr_r        <= page_addr_calc;
      end
      default: begin
      end
    endcase
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_stolen_r <= res_stolen_r;
      out_victim_r <= res_victim_r;
    end
  end

  // Next-pointer memory: written on a push, read when a head is popped.
  always_ff @(posedge clk) begin
    if (state_r == S_PUSH) begin
      link_mem[diff_r[IDX_W-1:0]] <= {head_vld_sel, head_idx_sel};
    end
    if (state_r == S_SCAN) begin
      rd_r <= link_mem[head_idx_sel];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_addr = out_addr_r;
  assign out_stolen     = out_stolen_r;
  assign out_victim_cpu = out_victim_r;

endmodule

// ===== sv/pcpa_checker.sv =====
// Port-level checks for the page allocator, bound to its top level.
// Depends on pcpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcpa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_status,
  input logic [pcpa_pkg::ADDR_W-1:0] out_alloc_addr,
  input logic                        out_stolen,
  input logic [2:0]                  out_victim_cpu
);

  // A stalled result stays offered.
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status), "result dropped while stalled")

  // A request holds the sequencer until its result is handed off, so the input is busy right after a transfer.
  `CHK_NEXT(a_busy_after_xfer, in_valid && !in_stall, in_stall, "request taken while busy")

  `CHK_ALWAYS(a_fail_zero, !(out_valid && out_status != pcpa_pkg::ST_ALLOC) || (out_alloc_addr == '0 && !out_stolen && out_victim_cpu == '0), "non-allocation result carries data")

  `CHK_ALWAYS(a_steal_alloc, !(out_valid && out_stolen) || out_status == pcpa_pkg::ST_ALLOC, "stolen flag without an allocation")

endmodule

bind per_cpu_page_free_list_allocator_top pcpa_checker u_pcpa_checker (.*);

// ===== tb/sv/per_cpu_page_free_list_allocator_top_test.sv =====
// Self-checking testbench for the per-CPU page free-list allocator.
// Depends on pcpa_pkg and the allocator RTL; a built-in predictor of the free lists
// checks every result transfer, over several base/top window settings.
`timescale 1ns / 100ps

module per_cpu_page_free_list_allocator_top_test;

  localparam int ADDR_W       = pcpa_pkg::ADDR_W;
  localparam int CPU_COUNT    = pcpa_pkg::CPU_COUNT_DEF;
  localparam int PAGE_COUNT   = pcpa_pkg::PAGE_COUNT_DEF;
  localparam int PAGE_SHIFT   = pcpa_pkg::PAGE_SHIFT_DEF;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [ADDR_W-1:0] PAGE_BYTES = 56'd1 << PAGE_SHIFT;
  localparam logic [ADDR_W-1:0] BASE_RST = pcpa_pkg::BASE_RST;
  localparam logic [ADDR_W-1:0] TOP_RST = pcpa_pkg::TOP_RST;

  typedef struct packed {
    logic        vld;
    logic [15:0] page;
  } page_ref_t;

  typedef struct packed {
    pcpa_pkg::req_mode_t mode;
    logic [2:0]          cpu;
    logic [ADDR_W-1:0]   addr;
  } page_req_t;

  typedef struct packed {
    pcpa_pkg::status_t status;
    logic [ADDR_W-1:0] addr;
    logic              stolen;
    logic [2:0]        victim;
  } alloc_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = 1'b0;
  logic [2:0]        in_cpu_id = '0;
  logic [ADDR_W-1:0] in_page_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_alloc_addr;
  logic              out_stolen;
  logic [2:0]        out_victim_cpu;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  per_cpu_page_free_list_allocator_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: window registers and the free lists.
  logic [ADDR_W-1:0] base_reg;
  logic [ADDR_W-1:0] top_reg;
  page_ref_t         free_head [CPU_COUNT];
  page_ref_t         free_link [PAGE_COUNT];

  page_req_t     req_q[$];
  alloc_result_t expected_q[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          in_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  page_req_t   drive_req;
  alloc_result_t want;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [63:0] first_page_no();
    return ({8'b0, base_reg} + ((64'd1 << PAGE_SHIFT) - 64'd1)) >> PAGE_SHIFT;
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr_of(logic [63:0] k);
    logic [63:0] a;
    a = (first_page_no() + k) << PAGE_SHIFT;
    return a[ADDR_W-1:0];
  endfunction

  // Number of page numbers that a free can currently reach.
  function automatic int unsigned window_pages();
    logic [63:0] lo;
    logic [63:0] span;
    lo = first_page_no() << PAGE_SHIFT;
    if (lo >= {8'b0, top_reg}) return 0;
    span = ({8'b0, top_reg} - lo + (64'd1 << PAGE_SHIFT) - 64'd1) >> PAGE_SHIFT;
    return (span > PAGE_COUNT) ? PAGE_COUNT : int'(span[31:0]);
  endfunction

  function automatic alloc_result_t serve_request(pcpa_pkg::req_mode_t mode,
                                                  logic [2:0] cpu,
                                                  logic [ADDR_W-1:0] pa);
    alloc_result_t r;
    logic [63:0]   idx;
    logic [2:0]    v;
    logic [2:0]    step;
    bit            ok;
    r = '{status: pcpa_pkg::ST_BAD, addr: '0, stolen: 1'b0, victim: '0};
    if (mode == pcpa_pkg::MODE_FREE) begin
      ok = (pa[PAGE_SHIFT-1:0] == '0) && (pa >= base_reg) && (pa < top_reg);
      idx = '0;
      if (ok) begin
        idx = ({8'b0, pa} >> PAGE_SHIFT) - first_page_no();
        ok = idx < PAGE_COUNT;
      end
      if (ok) begin
        free_link[idx] = free_head[cpu];
        free_head[cpu] = '{vld: 1'b1, page: idx[15:0]};
        r.status = pcpa_pkg::ST_FREED;
      end
    end else if (free_head[cpu].vld) begin
      idx = {48'b0, free_head[cpu].page};
      free_head[cpu] = free_link[idx];
      r.status = pcpa_pkg::ST_ALLOC;
      r.addr = page_addr_of(idx);
    end else begin
      r.status = pcpa_pkg::ST_OOM;
      // Rotating scan of the other CPUs, first non-empty list is taken whole.
      for (int i = 1; i < CPU_COUNT; i++) begin
        step = i[2:0];
        v = cpu + step;
        if (r.status == pcpa_pkg::ST_OOM && free_head[v].vld) begin
          idx = {48'b0, free_head[v].page};
          free_head[v] = '0;
          free_head[cpu] = free_link[idx];
          r.status = pcpa_pkg::ST_ALLOC;
          r.addr = page_addr_of(idx);
          r.stolen = 1'b1;
          r.victim = v;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    if (mismatch_count < 100)
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  // Input driver: pops pending requests, holds each one until its transfer.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 10) - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        drive_req = req_q.pop_front();
        in_valid <= 1'b1;
        in_mode <= drive_req.mode;
        in_cpu_id <= drive_req.cpu;
        in_page_addr <= drive_req.addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on each request transfer, checks each result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        expected_q.push_back(serve_request(pcpa_pkg::req_mode_t'(in_mode), in_cpu_id,
                                           in_page_addr));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result status", {62'b0, out_status}, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", {62'b0, out_status}, {62'b0, want.status});
          if (out_alloc_addr !== want.addr)
            report_mismatch("alloc_addr", {8'b0, out_alloc_addr}, {8'b0, want.addr});
          if (out_stolen !== want.stolen)
            report_mismatch("stolen", {63'b0, out_stolen}, {63'b0, want.stolen});
          if (out_victim_cpu !== want.victim)
            report_mismatch("victim_cpu", {61'b0, out_victim_cpu}, {61'b0, want.victim});
        end
      end
    end
  end

  task automatic queue_request(pcpa_pkg::req_mode_t mode, logic [2:0] cpu,
                               logic [ADDR_W-1:0] addr);
    req_q.push_back('{mode: mode, cpu: cpu, addr: addr});
  endtask

  task automatic write_reg(pcpa_pkg::cfg_reg_t idx, logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pcpa_pkg::CFG_BASE) base_reg = val;
    else top_reg = val;
  endtask

  // Waits until the block has handed off every result and gone quiet.
  task automatic settle();
    while (req_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly allocations and in-window frees on a few hot pages, plus bad addresses.
  task automatic queue_random(int n);
    int unsigned pages;
    int unsigned pick;
    int unsigned k;
    logic [2:0]  cpu;
    logic [63:0] noise;
    logic [63:0] a;
    pages = window_pages();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      cpu = 3'($urandom_range(0, CPU_COUNT - 1));
      noise = {$urandom, $urandom};
      if (pick < 45) begin
        queue_request(pcpa_pkg::MODE_ALLOC, cpu, noise[ADDR_W-1:0]);
      end else if (pick < 85 && pages > 0) begin
        if ($urandom_range(0, 3) == 0) k = $urandom_range(0, pages - 1);
        else k = $urandom_range(0, ((pages < 48) ? pages : 48) - 1);
        queue_request(pcpa_pkg::MODE_FREE, cpu, page_addr_of(k));
      end else begin
        case ($urandom_range(0, 3))
          0: a = noise;
          1: a = {8'b0, page_addr_of($urandom_range(0, 63))} |
                 64'($urandom_range(1, PAGE_BYTES - 1));
          2: a = (first_page_no() << PAGE_SHIFT) - 64'(PAGE_BYTES);
          default: begin
            if ($urandom_range(0, 1) == 0) a = (first_page_no() + PAGE_COUNT) << PAGE_SHIFT;
            else a = {8'b0, top_reg} & ~64'(PAGE_BYTES - 1);
          end
        endcase
        queue_request(pcpa_pkg::MODE_FREE, cpu, a[ADDR_W-1:0]);
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] b;
    base_reg = BASE_RST;
    top_reg = TOP_RST;
    for (int c = 0; c < CPU_COUNT; c++) free_head[c] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset window: exactly PAGE_COUNT pages from 0x8000_0000.
    write_reg(pcpa_pkg::CFG_BASE, BASE_RST);
    write_reg(pcpa_pkg::CFG_TOP, TOP_RST);
    queue_request(pcpa_pkg::MODE_ALLOC, 3'd0, '0);
    queue_request(pcpa_pkg::MODE_FREE, 3'd0, BASE_RST);
    queue_request(pcpa_pkg::MODE_FREE, 3'd0, TOP_RST - PAGE_BYTES);
    queue_request(pcpa_pkg::MODE_FREE, 3'd1, BASE_RST + 56'd1);
    queue_request(pcpa_pkg::MODE_FREE, 3'd1, BASE_RST - PAGE_BYTES);
    queue_request(pcpa_pkg::MODE_FREE, 3'd1, TOP_RST);
    queue_request(pcpa_pkg::MODE_FREE, 3'd1, ADDR_ONES);
    queue_request(pcpa_pkg::MODE_FREE, 3'd1, '0);
    queue_request(pcpa_pkg::MODE_ALLOC, 3'd0, ADDR_ONES);
    queue_request(pcpa_pkg::MODE_ALLOC, 3'd3, '0);
    queue_request(pcpa_pkg::MODE_ALLOC, 3'd3, '0);
    queue_request(pcpa_pkg::MODE_FREE, 3'd7, BASE_RST + 5 * PAGE_BYTES);
    queue_request(pcpa_pkg::MODE_FREE, 3'd7, BASE_RST + 6 * PAGE_BYTES);
    // The scan from CPU 0 reaches CPU 7; the scan from CPU 6 wraps to CPU 0.
    queue_request(pcpa_pkg::MODE_ALLOC, 3'd0, '0);
    queue_request(pcpa_pkg::MODE_ALLOC, 3'd6, '0);
    // Freeing the same page twice makes the list point at itself.
    queue_request(pcpa_pkg::MODE_FREE, 3'd2, BASE_RST + 9 * PAGE_BYTES);
    queue_request(pcpa_pkg::MODE_FREE, 3'd2, BASE_RST + 9 * PAGE_BYTES);
    repeat (3) queue_request(pcpa_pkg::MODE_ALLOC, 3'd2, '0);
    queue_request(pcpa_pkg::MODE_ALLOC, 3'd5, ADDR_ONES);
    queue_random(200);
    settle();

    // Whole address space open; only the page count limits the index.
    write_reg(pcpa_pkg::CFG_BASE, '0);
    write_reg(pcpa_pkg::CFG_TOP, ADDR_ONES);
    queue_request(pcpa_pkg::MODE_FREE, 3'd4, 56'(PAGE_COUNT - 1) << PAGE_SHIFT);
    queue_request(pcpa_pkg::MODE_FREE, 3'd4, 56'(PAGE_COUNT) << PAGE_SHIFT);
    queue_request(pcpa_pkg::MODE_ALLOC, 3'd4, '0);
    queue_random(160);
    settle();

    // Unaligned base, small window.
    b = 56'h12_3456_789A_BC;
    write_reg(pcpa_pkg::CFG_BASE, b);
    write_reg(pcpa_pkg::CFG_TOP, b + 37 * PAGE_BYTES + 56'd100);
    queue_random(160);
    settle();

    // Window at the very top of the address space.
    write_reg(pcpa_pkg::CFG_BASE, ADDR_ONES - 1024 * PAGE_BYTES + 56'd1);
    write_reg(pcpa_pkg::CFG_TOP, ADDR_ONES);
    queue_random(140);
    settle();

    // Nothing can be freed; the remaining pages come back at wrapped addresses.
    write_reg(pcpa_pkg::CFG_BASE, ADDR_ONES);
    write_reg(pcpa_pkg::CFG_TOP, '0);
    queue_random(60);
    settle();

    // Final stretch at full rate with the reset window.
    quiet = 1'b1;
    write_reg(pcpa_pkg::CFG_BASE, BASE_RST);
    write_reg(pcpa_pkg::CFG_TOP, TOP_RST);
    queue_random(100);
    settle();

    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== per_cpu_page_free_list_allocator_top.f =====
+incdir+sv
sv/pcpa_pkg.sv
sv/pcpa_addsub.sv
sv/per_cpu_page_free_list_allocator_top.sv
sv/pcpa_checker.sv
tb/sv/per_cpu_page_free_list_allocator_top_test.sv
